// ===== hdl/ttl_entry_table_defines.svh =====
// Assertion macros shared by the ttl entry table modules.
`ifndef TTL_ENTRY_TABLE_DEFINES_SVH
`define TTL_ENTRY_TABLE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define TTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define TTL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/ttl_pkg.sv =====
// Shared types and constants of the ttl entry table.
package ttl_pkg;

  localparam int TIME_W = 32;
  localparam int KEY_W  = 32;
  localparam int CNT_W  = 5;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_FIND  = 2'd1,
    ACT_CLEAN = 2'd2
  } ttl_action_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [TIME_W-1:0] now;
    logic [KEY_W-1:0]  data_word;
    logic [TIME_W-1:0] ttl_ms;
  } ttl_req_t;

  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] found_data;
    logic [CNT_W-1:0] removed_count;
    logic [CNT_W-1:0] entry_count;
  } ttl_rsp_t;

  typedef struct packed {
    logic load;
    logic step;
  } ttl_cmd_t;

  typedef struct packed {
    logic last;
  } ttl_stat_t;

endpackage

// ===== hdl/ttl_ctrl.sv =====
// Sequencing state machine of the ttl entry table.
`include "ttl_entry_table_defines.svh"

module ttl_ctrl
  import ttl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output logic      done_o,
  output ttl_cmd_t  cmd_o,
  input  ttl_stat_t stat_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.last) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_LAST);
    end
  end

  assign busy       = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign cmd_o.load = (state_q == ST_IDLE) && start;
  assign cmd_o.step = (state_q == ST_SCAN);

  `TTL_ASSERT(a_done_then_idle, done_q |=> (state_q == ST_IDLE), "strobe not followed by idle")
  `TTL_ASSERT(a_last_then_done, (state_q == ST_LAST) |=> done_q, "final slot without response")
  `TTL_ASSERT(a_start_scans, (start && !busy) |=> (state_q == ST_SCAN), "accepted start lost")

endmodule

// ===== hdl/ttl_dpath.sv =====
// Slot storage, scan index and result registers of the ttl entry table.
`include "ttl_entry_table_defines.svh"

module ttl_dpath
  import ttl_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ttl_cmd_t  cmd_i,
  output ttl_stat_t stat_o,
  input  ttl_req_t  req_i,
  output ttl_rsp_t  rsp_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (DATA_WIDTH < KEY_W) ? DATA_WIDTH : KEY_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  logic [TIME_W-1:0] exp_mem [CAPACITY];
  logic [SW-1:0]     dat_mem [CAPACITY];

  ttl_req_t          op_q;
  logic [IW-1:0]     idx_q, idx_d;
  logic              ev_q, ev_d;
  logic [IW-1:0]     ev_idx_q;
  logic [TIME_W-1:0] exp_rd_q;
  logic [SW-1:0]     dat_rd_q;
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [CW-1:0]     count_q, count_d;
  logic              ok_q, ok_d;
  logic [SW-1:0]     found_q, found_d;
  logic [CW-1:0]     removed_q, removed_d;

  logic [SW-1:0]     key;
  logic              expired;
  logic              add_wr;

  assign key     = op_q.data_word[SW-1:0];
  assign expired = (op_q.now >= exp_rd_q);
  assign add_wr  = cmd_i.step && (op_q.action == ACT_ADD) && !ok_q && !valid_q[idx_q];

  always_comb begin
    valid_d   = valid_q;
    count_d   = count_q;
    ok_d      = ok_q;
    found_d   = found_q;
    removed_d = removed_q;
    idx_d     = idx_q;
    ev_d      = 1'b0;
    if (cmd_i.load) begin
      idx_d     = '0;
      ok_d      = (req_i.action == ACT_CLEAN);
      found_d   = '0;
      removed_d = '0;
    end else begin
      if (cmd_i.step) begin
        ev_d = 1'b1;
        if (idx_q != LAST_IDX) begin
          idx_d = idx_q + 1'b1;
        end
        if (add_wr) begin
          valid_d[idx_q] = 1'b1;
          count_d        = count_q + 1'b1;
          ok_d           = 1'b1;
        end
      end
      if (ev_q) begin
        if ((op_q.action == ACT_FIND) && !ok_q && valid_q[ev_idx_q] && !expired &&
            (dat_rd_q == key)) begin
          ok_d    = 1'b1;
          found_d = dat_rd_q;
        end
        if ((op_q.action == ACT_CLEAN) && valid_q[ev_idx_q] && expired) begin
          valid_d[ev_idx_q] = 1'b0;
          count_d           = count_q - 1'b1;
          removed_d         = removed_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      count_q   <= '0;
      ok_q      <= 1'b0;
      found_q   <= '0;
      removed_q <= '0;
      idx_q     <= '0;
      ev_q      <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      count_q   <= count_d;
      ok_q      <= ok_d;
      found_q   <= found_d;
      removed_q <= removed_d;
      idx_q     <= idx_d;
      ev_q      <= ev_d;
    end
  end

  // Hold the transaction and the slot under evaluation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= req_i;
    end
    if (cmd_i.step) begin
      ev_idx_q <= idx_q;
    end
  end

  // Single-port slot memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (add_wr) begin
      exp_mem[idx_q] <= op_q.now + op_q.ttl_ms;
      dat_mem[idx_q] <= key;
    end
    if (cmd_i.step) begin
      exp_rd_q <= exp_mem[idx_q];
      dat_rd_q <= dat_mem[idx_q];
    end
  end

  assign stat_o.last         = (idx_q == LAST_IDX);
  assign rsp_o.ok            = ok_q;
  assign rsp_o.found_data    = KEY_W'(found_q);
  assign rsp_o.removed_count = CNT_W'(removed_q);
  assign rsp_o.entry_count   = CNT_W'(count_q);

  `TTL_ASSERT_ALWAYS(a_count_matches, (!rst_ni) || (count_q == $countones(valid_q)), "entry count drift")
  `TTL_ASSERT(a_miss_no_data, !ok_q |-> (found_q == '0), "data reported without hit")
  `TTL_ASSERT(a_load_rewinds, cmd_i.load |=> (idx_q == '0), "scan index not rewound")

endmodule

// ===== hdl/ttl_entry_table.sv =====
// Top level of the ttl entry table: controller plus slot datapath.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+-----------------------------
//   request   | start in, busy out      | req_i  (action, now, data, ttl)
//   response  | done_o out, no stall    | rsp_o  (ok, data, counts)
//
// A transaction is taken on a rising edge with start high and busy low.
// The scan then steps through every slot in turn, ST_LAST evaluates the last
// registered read, and ST_RESP presents the response with done_o registered.
// Busy then drops, and a new transaction is taken only while busy is low.
// done_o is high for exactly one cycle; the receiver must take it then.
// Reset clears the valid bits at once, so no clearing pass is needed.
`include "ttl_entry_table_defines.svh"

module ttl_entry_table
  import ttl_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  ttl_req_t req_i,
  output logic     done_o,
  output ttl_rsp_t rsp_o
);

  ttl_cmd_t  cmd;
  ttl_stat_t stat;

  // Sequence the scan: load, step one slot per cycle, respond.
  ttl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // Hold slots, evaluate each slot against the captured transaction.
  ttl_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

  `TTL_ASSERT(a_done_while_busy, done_o |-> busy, "response outside a transaction")
  `TTL_ASSERT(a_done_single, done_o |=> !done_o, "response strobe longer than one cycle")
  `TTL_ASSERT(a_accept_busy, (start && !busy) |=> (busy && !done_o), "accepted start not busy")

endmodule
